// ----- rtl/tcra_pkg.sv -----
// tcra_pkg: sizes, structs and state codes of the two-class rank assigner
// used by tcra_if, tcra_cell, tcra_ctrl and two_class_rank_assigner
`default_nettype none

package tcra_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IW = $clog2(MAX_ITEMS);      // cell index
	localparam int CW = $clog2(MAX_ITEMS + 1);  // fill count, holds MAX_ITEMS
	localparam int VW = 16;                     // item value
	localparam int RW = 7;                      // rank

	localparam logic [RW-1:0] RANK_BASE = RW'(1);

	// travelling count request: walks the cell row one cell per cycle
	typedef struct packed {
		logic          vld;
		logic [VW-1:0] value;
		logic          liked;
		logic [IW-1:0] idx;
		logic [RW-1:0] cnt;
	} tok_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic          load;
		logic [VW-1:0] value;
		logic          liked;
		logic [IW-1:0] idx;
		logic [CW-1:0] fill;
		logic          shift;
		logic          wb_vld;
		logic [IW-1:0] wb_idx;
		logic [RW-1:0] wb_cnt;
	} bcast_t;

	typedef struct packed {
		logic in_fire;
		logic in_last;
		logic out_fire;
		logic tok_busy;
	} ctrl_in_t;

	typedef struct packed {
		logic          in_ready;
		logic          out_valid;
		logic          store;
		logic [CW-1:0] fill;
		logic          emit_last;
		logic          drop;
	} ctrl_out_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/tcra_if.sv -----
// tcra_item_if and tcra_rank_if: valid/ready channels of the rank assigner
// depends on tcra_pkg for field widths
`default_nettype none

interface tcra_item_if;
	logic                   valid;
	logic                   ready;
	logic [tcra_pkg::VW-1:0] item_value;
	logic                   liked;
	logic                   last_item;

	modport source (output valid, item_value, liked, last_item, input ready);
	modport sink (input valid, item_value, liked, last_item, output ready);
endinterface

interface tcra_rank_if;
	logic                   valid;
	logic                   ready;
	logic [tcra_pkg::RW-1:0] new_rank;
	logic                   last_rank;
	logic                   overflow;

	modport source (output valid, new_rank, last_rank, overflow, input ready);
	modport sink (input valid, new_rank, last_rank, overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcra_cell.sv -----
// tcra_cell: one slot of the rank row, holds an item, its rank and a count stage
// depends on tcra_pkg
`default_nettype none

module tcra_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [tcra_pkg::IW-1:0]  cell_idx,
	input  wire tcra_pkg::bcast_t         bc,
	input  wire tcra_pkg::tok_t           tok_in,
	output tcra_pkg::tok_t                tok_out,
	input  wire logic [tcra_pkg::RW-1:0]  rank_nxt,
	output logic [tcra_pkg::RW-1:0]       rank
);

	logic [tcra_pkg::VW-1:0] value_q;
	logic                    liked_q;
	logic [tcra_pkg::RW-1:0] rank_q;
	logic [tcra_pkg::RW-1:0] rank_d;
	tcra_pkg::tok_t          tok_pl_q;
	tcra_pkg::tok_t          tok_d;
	logic                    tok_vld_q;

	logic held;
	logic hit_load;
	logic new_first;
	logic bump;
	logic wb_hit;
	logic earlier;
	logic me_first;

	assign held     = tcra_pkg::CW'(cell_idx) < bc.fill;
	assign hit_load = bc.load && (bc.idx == cell_idx);

	// incoming item ranks ahead of this one (ties go to the older item)
	assign new_first = (!bc.liked && liked_q) ||
		((bc.liked == liked_q) && (bc.value < value_q));
	assign bump   = bc.load && held && new_first;
	assign wb_hit = bc.wb_vld && (bc.wb_idx == cell_idx);

	// this older item ranks ahead of the travelling one
	assign earlier  = cell_idx < tok_in.idx;
	assign me_first = (!liked_q && tok_in.liked) ||
		((liked_q == tok_in.liked) && (value_q <= tok_in.value));

	always_comb begin
		if (hit_load) begin
			rank_d = tcra_pkg::RANK_BASE;
		end else if (bc.shift) begin
			rank_d = rank_nxt;
		end else begin
			rank_d = rank_q + tcra_pkg::RW'(bump) + (wb_hit ? bc.wb_cnt : '0);
		end
	end

	always_comb begin
		tok_d     = tok_in;
		tok_d.cnt = tok_in.cnt + tcra_pkg::RW'(tok_in.vld && earlier && me_first);
	end

	always_ff @(posedge clk) begin
		if (hit_load) begin
			value_q <= bc.value;
			liked_q <= bc.liked;
		end
		rank_q   <= rank_d;
		tok_pl_q <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	always_comb begin
		tok_out     = tok_pl_q;
		tok_out.vld = tok_vld_q;
	end

	assign rank = rank_q;

endmodule

`default_nettype wire

// ----- rtl/tcra_ctrl.sv -----
// tcra_ctrl: load / drain / emit sequencer with fill count and drop flag
// depends on tcra_pkg
`default_nettype none

module tcra_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tcra_pkg::ctrl_in_t  ci,
	output tcra_pkg::ctrl_out_t      co
);

	tcra_pkg::state_t        state_q;
	tcra_pkg::state_t        state_d;
	logic [tcra_pkg::CW-1:0] fill_q;
	logic [tcra_pkg::IW-1:0] emit_q;
	logic                    drop_q;
	logic                    emit_last;
	logic                    has_room;

	assign has_room  = fill_q < tcra_pkg::CW'(tcra_pkg::MAX_ITEMS);
	assign emit_last = (tcra_pkg::CW'(emit_q) + tcra_pkg::CW'(1)) == fill_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcra_pkg::ST_LOAD: begin
				if (ci.in_fire && ci.in_last) state_d = tcra_pkg::ST_DRAIN;
			end
			tcra_pkg::ST_DRAIN: begin
				if (!ci.tok_busy) state_d = tcra_pkg::ST_EMIT;
			end
			tcra_pkg::ST_EMIT: begin
				if (ci.out_fire && emit_last) state_d = tcra_pkg::ST_LOAD;
			end
			default: state_d = tcra_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		co.in_ready  = 1'b0;
		co.out_valid = 1'b0;
		case (state_q)
			tcra_pkg::ST_LOAD: co.in_ready  = 1'b1;
			tcra_pkg::ST_EMIT: co.out_valid = 1'b1;
			default: ;
		endcase
		co.store     = has_room;
		co.fill      = fill_q;
		co.emit_last = emit_last;
		co.drop      = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcra_pkg::ST_LOAD;
			fill_q  <= '0;
			emit_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ci.in_fire) begin
				if (has_room) begin
					fill_q <= fill_q + tcra_pkg::CW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (ci.out_fire) begin
				if (emit_last) begin
					fill_q <= '0;
					emit_q <= '0;
					drop_q <= 1'b0;
				end else begin
					emit_q <= emit_q + tcra_pkg::IW'(1);
				end
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tcra_pkg::CW'(tcra_pkg::MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (fill_q == tcra_pkg::CW'(tcra_pkg::MAX_ITEMS)))
		else $error("drop flag set with room left");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcra_pkg::ST_EMIT) |-> (fill_q != '0))
		else $error("emitting an empty set");

	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ci.in_fire && ci.in_last) |=> (state_q == tcra_pkg::ST_DRAIN))
		else $error("last item did not start the drain");

endmodule

`default_nettype wire

// ----- rtl/two_class_rank_assigner.sv -----
// two_class_rank_assigner: top level, row of tcra_cell slots under tcra_ctrl
// depends on tcra_pkg, tcra_if, tcra_cell, tcra_ctrl
`default_nettype none

// Items of a set stream in at one request per cycle and are kept in input
// order, one per cell of a row of MAX_ITEMS cells. On every load the new item
// is compared with all held items at once, so each held rank moves up when
// the newcomer sorts ahead of it (unliked before liked, then by value, older
// first on a tie). The newcomer's own count of older items ahead of it is
// gathered by a count request that walks the row one cell per cycle and is
// added into the item's cell when it leaves the last cell. After the request
// marked last_item, the block takes no input until the walk of the whole
// cell row is done. Then it gives one result per stored item, in input
// order, one per cycle as the sink takes them, by shifting the ranks down
// the row toward cell 0; input stays closed until the last result is taken.
// Items beyond MAX_ITEMS are not stored but still end the set when marked
// last, and every result of such a set carries overflow.

module two_class_rank_assigner (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tcra_item_if.sink     items,
	tcra_rank_if.source   ranks
);

	tcra_pkg::ctrl_in_t  ci;
	tcra_pkg::ctrl_out_t co;
	tcra_pkg::bcast_t    bc;
	tcra_pkg::tok_t      tok_ch [tcra_pkg::MAX_ITEMS+1];
	logic [tcra_pkg::RW-1:0]       rank_v [tcra_pkg::MAX_ITEMS];
	logic [tcra_pkg::MAX_ITEMS-1:0] tok_vld;

	logic in_fire;
	logic out_fire;
	logic load;

	assign in_fire  = items.valid && items.ready;
	assign out_fire = ranks.valid && ranks.ready;
	assign load     = in_fire && co.store;

	// sequencer
	assign ci.in_fire  = in_fire;
	assign ci.in_last  = items.last_item;
	assign ci.out_fire = out_fire;
	assign ci.tok_busy = |tok_vld;

	tcra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.ci     (ci),
		.co     (co)
	);

	assign items.ready = co.in_ready;

	// count request for the new item enters at cell 0
	assign tok_ch[0].vld   = load;
	assign tok_ch[0].value = items.item_value;
	assign tok_ch[0].liked = items.liked;
	assign tok_ch[0].idx   = co.fill[tcra_pkg::IW-1:0];
	assign tok_ch[0].cnt   = '0;

	// broadcast: load into the next free cell, shift on emit, count write-back
	assign bc.load   = load;
	assign bc.value  = items.item_value;
	assign bc.liked  = items.liked;
	assign bc.idx    = co.fill[tcra_pkg::IW-1:0];
	assign bc.fill   = co.fill;
	assign bc.shift  = out_fire;
	assign bc.wb_vld = tok_ch[tcra_pkg::MAX_ITEMS].vld;
	assign bc.wb_idx = tok_ch[tcra_pkg::MAX_ITEMS].idx;
	assign bc.wb_cnt = tok_ch[tcra_pkg::MAX_ITEMS].cnt;

	for (genvar k = 0; k < tcra_pkg::MAX_ITEMS; k++) begin : g_cell
		logic [tcra_pkg::RW-1:0] rank_nxt;

		if (k == tcra_pkg::MAX_ITEMS - 1) begin : g_end
			assign rank_nxt = '0;
		end else begin : g_mid
			assign rank_nxt = rank_v[k+1];
		end

		tcra_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (tcra_pkg::IW'(k)),
			.bc       (bc),
			.tok_in   (tok_ch[k]),
			.tok_out  (tok_ch[k+1]),
			.rank_nxt (rank_nxt),
			.rank     (rank_v[k])
		);

		assign tok_vld[k] = tok_ch[k+1].vld;
	end

	// results come out of cell 0 in input order
	assign ranks.valid     = co.out_valid;
	assign ranks.new_rank  = rank_v[0];
	assign ranks.last_rank = co.emit_last;
	assign ranks.overflow  = co.drop;

	a_no_emit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ranks.valid |-> !(|tok_vld))
		else $error("result shown while counts still walking the row");

	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ranks.valid |-> ((ranks.new_rank != '0) &&
			(tcra_pkg::CW'(ranks.new_rank) <= co.fill)))
		else $error("rank outside the set size");

	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && ranks.valid))
		else $error("loading while results are out");

endmodule

`default_nettype wire
